// ----- design/ppis_pkg.sv -----
`default_nettype none

package ppis_pkg;

    localparam int ERR_W   = 17;
    localparam int GAIN_W  = 24;
    localparam int LIMIT_W = 31;
    localparam int THR_W   = 17;
    localparam int DRIVE_W = 32;

    typedef enum logic [2:0] {
        REG_KP        = 3'd0,
        REG_KI        = 3'd1,
        REG_KD        = 3'd2,
        REG_INT_LIMIT = 3'd3,
        REG_OUT_LIMIT = 3'd4,
        REG_SEP_THR   = 3'd5
    } ppis_reg_idx_t;

    typedef struct packed {
        logic [GAIN_W-1:0]  proportional_gain;
        logic [GAIN_W-1:0]  integral_gain;
        logic [GAIN_W-1:0]  derivative_gain;
        logic [LIMIT_W-1:0] integral_limit;
        logic [LIMIT_W-1:0] output_limit;
        logic [THR_W-1:0]   separation_threshold;
    } ppis_cfg_t;

    typedef struct packed {
        logic               clear_state;
        logic signed [15:0] measured;
        logic signed [15:0] setpoint;
    } ppis_item_t;

    typedef struct packed {
        logic                      integral_excluded;
        logic                      drive_clamped;
        logic signed [DRIVE_W-1:0] drive;
    } ppis_result_t;

endpackage

`default_nettype wire

// ----- design/ppis_cfg.sv -----
`default_nettype none

module ppis_cfg
    import ppis_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire logic [2:0]         cfg_addr,
    input  wire logic [LIMIT_W-1:0] cfg_wdata,
    output ppis_cfg_t               cfg
);

    ppis_cfg_t cfg_reg;
    ppis_cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (ppis_reg_idx_t'(cfg_addr))
                REG_KP:        cfg_next.proportional_gain    = cfg_wdata[GAIN_W-1:0];
                REG_KI:        cfg_next.integral_gain        = cfg_wdata[GAIN_W-1:0];
                REG_KD:        cfg_next.derivative_gain      = cfg_wdata[GAIN_W-1:0];
                REG_INT_LIMIT: cfg_next.integral_limit       = cfg_wdata;
                REG_OUT_LIMIT: cfg_next.output_limit         = cfg_wdata;
                REG_SEP_THR:   cfg_next.separation_threshold = cfg_wdata[THR_W-1:0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.proportional_gain    <= '0;
            cfg_reg.integral_gain        <= '0;
            cfg_reg.derivative_gain      <= '0;
            cfg_reg.integral_limit       <= '0;
            cfg_reg.output_limit         <= '0;
            cfg_reg.separation_threshold <= '1;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ----- design/ppis_core.sv -----
`default_nettype none

module ppis_core
    import ppis_pkg::*;
#(
    parameter int GAIN_FRAC_BITS = 12
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire ppis_cfg_t  cfg,
    input  wire logic  fire,
    input  wire ppis_item_t item,
    output ppis_result_t result
);

    localparam int KW    = GAIN_W + 1;
    localparam int DE_W  = ERR_W + 1;
    localparam int P_W   = KW + ERR_W;
    localparam int D_W   = KW + DE_W;
    localparam int I_W   = P_W + 1;
    localparam int SUM_W = D_W + 3;

    logic signed [ERR_W-1:0]   prev_err_reg;
    logic signed [ERR_W-1:0]   prev_err_next;
    logic signed [DRIVE_W-1:0] integral_reg;
    logic signed [DRIVE_W-1:0] integral_next;

    logic signed [ERR_W-1:0] err;
    logic signed [DE_W-1:0]  derr;
    logic signed [P_W-1:0]   p_prod;
    logic signed [P_W-1:0]   i_prod;
    logic signed [D_W-1:0]   d_prod;
    logic signed [P_W-1:0]   p_term;
    logic signed [P_W-1:0]   i_term;
    logic signed [D_W-1:0]   d_term;
    logic signed [I_W-1:0]   i_cand;
    logic signed [I_W-1:0]   i_lim;
    logic signed [DRIVE_W-1:0] i_clamped;
    logic [ERR_W-1:0]        err_mag;
    logic                    excluded;
    logic signed [SUM_W-1:0] sum;
    logic signed [SUM_W-1:0] o_lim;

    always_comb
    begin
        err    = {item.setpoint[15], item.setpoint} - {item.measured[15], item.measured};
        derr   = {err[ERR_W-1], err} - {prev_err_reg[ERR_W-1], prev_err_reg};
        p_prod = P_W'($signed({1'b0, cfg.proportional_gain})) * P_W'(err);
        i_prod = P_W'($signed({1'b0, cfg.integral_gain})) * P_W'(err);
        d_prod = D_W'($signed({1'b0, cfg.derivative_gain})) * D_W'(derr);
        p_term = p_prod >>> GAIN_FRAC_BITS;
        i_term = i_prod >>> GAIN_FRAC_BITS;
        d_term = d_prod >>> GAIN_FRAC_BITS;

        i_cand = I_W'(integral_reg) + I_W'(i_term);
        i_lim  = $signed({{(I_W-LIMIT_W){1'b0}}, cfg.integral_limit});
        if (i_cand > i_lim)
            i_clamped = DRIVE_W'(i_lim);
        else if (i_cand < -i_lim)
            i_clamped = DRIVE_W'(-i_lim);
        else
            i_clamped = DRIVE_W'(i_cand);

        err_mag  = err[ERR_W-1] ? ERR_W'(-err) : ERR_W'(err);
        excluded = err_mag >= cfg.separation_threshold;

        sum = SUM_W'(p_term) + SUM_W'(d_term)
            + (excluded ? SUM_W'(0) : SUM_W'(i_clamped));
        o_lim = $signed({{(SUM_W-LIMIT_W){1'b0}}, cfg.output_limit});

        result.integral_excluded = excluded;
        if (sum > o_lim)
        begin
            result.drive         = DRIVE_W'(o_lim);
            result.drive_clamped = 1'b1;
        end
        else if (sum < -o_lim)
        begin
            result.drive         = DRIVE_W'(-o_lim);
            result.drive_clamped = 1'b1;
        end
        else
        begin
            result.drive         = DRIVE_W'(sum);
            result.drive_clamped = 1'b0;
        end

        prev_err_next = err;
        integral_next = i_clamped;

        if (item.clear_state)
        begin
            result        = '0;
            prev_err_next = '0;
            integral_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_err_reg <= '0;
            integral_reg <= '0;
        end
        else if (fire)
        begin
            prev_err_reg <= prev_err_next;
            integral_reg <= integral_next;
        end
    end

endmodule

`default_nettype wire

// ----- design/position_pid_integral_separation.sv -----
// Channel   Direction  tdata                                tuser
// s_axis    in         [15:0] setpoint, [31:16] measured    [0] clear_state
// m_axis    out        [31:0] drive                         [0] drive_clamped,
//                                                            [1] integral_excluded
// cfg       in         cfg_wdata to register cfg_addr when cfg_we is high
//
// One beat per cycle sustained while m_axis_tready stays high; an input beat passes
// through the input register and then the result register. The combinational multiply,
// integral update and output clamp between those two registers set the rate.
// Reset clears the gains and limits to zero, the separation threshold to all ones,
// the stored integral and previous error to zero, and empties both registers.
// A stalled result holds; the input register takes one more beat while the result
// waits, then the input stalls.
`default_nettype none

module position_pid_integral_separation
    import ppis_pkg::*;
#(
    parameter int GAIN_FRAC_BITS = 12
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               s_axis_tvalid,
    output logic                    s_axis_tready,
    input  wire logic [31:0]        s_axis_tdata,   // [15:0] setpoint, [31:16] measured
    input  wire logic               s_axis_tuser,   // [0] clear_state
    output logic                    m_axis_tvalid,
    input  wire logic               m_axis_tready,
    output logic [DRIVE_W-1:0]      m_axis_tdata,   // [31:0] drive
    output logic [1:0]              m_axis_tuser,   // [0] drive_clamped, [1] integral_excluded
    input  wire logic               cfg_we,
    input  wire logic [2:0]         cfg_addr,
    input  wire logic [LIMIT_W-1:0] cfg_wdata
);

    ppis_cfg_t    cfg;
    ppis_item_t   in_item_reg;
    logic         in_valid_reg;
    ppis_result_t out_result_reg;
    logic         out_valid_reg;
    ppis_result_t result;
    logic         advance;
    logic         fire;

    ppis_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    ppis_core #(
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .fire   (fire),
        .item   (in_item_reg),
        .result (result)
    );

    assign advance       = !out_valid_reg || m_axis_tready;
    assign fire          = in_valid_reg && advance;
    assign s_axis_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
                in_valid_reg <= s_axis_tvalid;
            if (advance)
                out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_item_reg.setpoint    <= s_axis_tdata[15:0];
            in_item_reg.measured    <= s_axis_tdata[31:16];
            in_item_reg.clear_state <= s_axis_tuser;
        end
        if (fire)
            out_result_reg <= result;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_result_reg.drive;
    assign m_axis_tuser  = {out_result_reg.integral_excluded, out_result_reg.drive_clamped};

endmodule

`default_nettype wire

// ----- design/ppis_checker.sv -----
`default_nettype none

module ppis_checker
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [31:0] m_axis_tdata,
    input wire logic [1:0]  m_axis_tuser
);

    a_empty_in_reset: assert property (@(posedge clk)
        !rst_n |=> !m_axis_tvalid)
        else $error("result beat shown during reset");

    a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser))
        else $error("stalled result beat changed");

    a_drive_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata != 32'h8000_0000)
        else $error("drive beyond symmetric range");

    a_flow_through: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tready |-> s_axis_tready)
        else $error("input stalled while output drains");

endmodule

bind position_pid_integral_separation ppis_checker u_ppis_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

// ----- verif/tb_top.sv -----
module tb_top
    import ppis_pkg::*;
;

    localparam int FRAC_BITS = 12;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAX_PRINTED = 100;
    localparam logic [2:0] REG_SPARE_A = 3'd6;
    localparam logic [2:0] REG_SPARE_B = 3'd7;
    localparam int RANDOM_PHASES = 8;
    localparam int ITEMS_PER_PHASE = 250;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [31:0] s_axis_tdata = '0;
    logic s_axis_tuser = 1'b0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [DRIVE_W-1:0] m_axis_tdata;
    logic [1:0] m_axis_tuser;
    logic cfg_we = 1'b0;
    logic [2:0] cfg_addr = '0;
    logic [LIMIT_W-1:0] cfg_wdata = '0;

    bit idle_on = 1'b1;
    int quiet_cycles = 0;

    class pid_drive_model;
        logic [GAIN_W-1:0] kp;
        logic [GAIN_W-1:0] ki;
        logic [GAIN_W-1:0] kd;
        logic [LIMIT_W-1:0] int_limit;
        logic [LIMIT_W-1:0] out_limit;
        logic [THR_W-1:0] sep_thr;
        longint last_error;
        longint integral;
        ppis_result_t expected_drive[$];
        int errors;

        function new();
            kp = '0;
            ki = '0;
            kd = '0;
            int_limit = '0;
            out_limit = '0;
            sep_thr = '1;
            last_error = 0;
            integral = 0;
            errors = 0;
        endfunction

        function int pending();
            return expected_drive.size();
        endfunction

        function void write_reg(logic [2:0] idx, logic [LIMIT_W-1:0] value);
            case (idx)
                REG_KP:        kp = value[GAIN_W-1:0];
                REG_KI:        ki = value[GAIN_W-1:0];
                REG_KD:        kd = value[GAIN_W-1:0];
                REG_INT_LIMIT: int_limit = value;
                REG_OUT_LIMIT: out_limit = value;
                REG_SEP_THR:   sep_thr = value[THR_W-1:0];
                default:       ;
            endcase
        endfunction

        function longint clamp(longint x, longint lim, output bit hit);
            hit = 1'b0;
            if (x > lim)
            begin
                hit = 1'b1;
                return lim;
            end
            if (x < -lim)
            begin
                hit = 1'b1;
                return -lim;
            end
            return x;
        endfunction

        function void accept_sample(logic signed [15:0] sp, logic signed [15:0] ms, bit clr);
            longint err, derr, p_term, d_term, total, mag, gain, lim, thr, drv;
            bit int_hit, excluded, clamped;
            ppis_result_t r;
            r = '0;
            if (clr)
            begin
                last_error = 0;
                integral = 0;
                expected_drive.push_back(r);
                return;
            end
            err = longint'(sp) - longint'(ms);
            derr = err - last_error;
            gain = longint'(kp);
            p_term = (gain * err) >>> FRAC_BITS;
            gain = longint'(kd);
            d_term = (gain * derr) >>> FRAC_BITS;
            gain = longint'(ki);
            lim = longint'(int_limit);
            integral = clamp(integral + ((gain * err) >>> FRAC_BITS), lim, int_hit);
            mag = (err < 0) ? -err : err;
            thr = longint'(sep_thr);
            excluded = (mag >= thr);
            total = p_term + d_term + (excluded ? 64'sd0 : integral);
            lim = longint'(out_limit);
            drv = clamp(total, lim, clamped);
            last_error = err;
            r.drive = drv[DRIVE_W-1:0];
            r.drive_clamped = clamped;
            r.integral_excluded = excluded;
            expected_drive.push_back(r);
        endfunction

        task report(string msg);
            if (errors < MAX_PRINTED)
                $display("[%0t] mismatch: %s", $realtime, msg);
            errors++;
        endtask

        task check_drive(logic [DRIVE_W-1:0] data, logic [1:0] user);
            ppis_result_t want;
            if (expected_drive.size() == 0)
            begin
                report($sformatf("beat with nothing expected, drive=%0d", $signed(data)));
                return;
            end
            want = expected_drive.pop_front();
            if (data !== want.drive)
                report($sformatf("drive got %0d want %0d", $signed(data), want.drive));
            if (user[0] !== want.drive_clamped)
                report($sformatf("drive_clamped got %b want %b", user[0], want.drive_clamped));
            if (user[1] !== want.integral_excluded)
                report($sformatf("integral_excluded got %b want %b",
                                 user[1], want.integral_excluded));
        endtask
    endclass

    pid_drive_model pid = new();

    position_pid_integral_separation dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
                pid.accept_sample(s_axis_tdata[15:0], s_axis_tdata[31:16], s_axis_tuser);
            if (m_axis_tvalid && m_axis_tready)
                pid.check_drive(m_axis_tdata, m_axis_tuser);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we)
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("FAIL position_pid_integral_separation");
                $finish;
            end
        end
    end

    initial
    begin
        int stall;
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            stall = idle_on ? $urandom_range(0, 10) : 0;
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge clk); while (!m_axis_tvalid);
        end
    end

    task automatic send_sample(logic signed [15:0] sp, logic signed [15:0] ms, bit clr);
        int gap;
        gap = idle_on ? $urandom_range(0, 10) : 0;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {ms, sp};
        s_axis_tuser <= clr;
        do @(posedge clk); while (!s_axis_tready);
    endtask

    task automatic program_reg(logic [2:0] idx, logic [LIMIT_W-1:0] value);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        pid.write_reg(idx, value);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic settle();
        s_axis_tvalid <= 1'b0;
        do @(posedge clk); while (pid.pending() != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic program_all(logic [GAIN_W-1:0] p, logic [GAIN_W-1:0] i,
                               logic [GAIN_W-1:0] d, logic [LIMIT_W-1:0] ilim,
                               logic [LIMIT_W-1:0] olim, logic [THR_W-1:0] thr);
        program_reg(REG_KP, LIMIT_W'(p));
        program_reg(REG_KI, LIMIT_W'(i));
        program_reg(REG_KD, LIMIT_W'(d));
        program_reg(REG_INT_LIMIT, ilim);
        program_reg(REG_OUT_LIMIT, olim);
        program_reg(REG_SEP_THR, LIMIT_W'(thr));
    endtask

    function automatic logic [LIMIT_W-1:0] pick_value(int width);
        logic [LIMIT_W-1:0] mask;
        mask = LIMIT_W'((32'h1 << width) - 1);
        case ($urandom_range(0, 5))
            0: return '0;
            1: return mask;
            2: return LIMIT_W'($urandom_range(0, 64));
            3: return LIMIT_W'($urandom_range(0, 8192));
            default: return LIMIT_W'($urandom) & mask;
        endcase
    endfunction

    function automatic logic [THR_W-1:0] pick_threshold();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2: return 17'd65536;
            3: return THR_W'($urandom_range(0, 2048));
            default: return THR_W'($urandom_range(0, 65535));
        endcase
    endfunction

    task automatic random_sample();
        logic signed [15:0] sp;
        logic signed [15:0] ms;
        int pick;
        pick = $urandom_range(0, 19);
        sp = 16'($urandom);
        if (pick == 0)
            send_sample(sp, 16'($urandom), 1'b1);
        else if (pick < 8)
            send_sample(sp, 16'($urandom), 1'b0);
        else
        begin
            ms = sp + 16'($urandom_range(0, 2048) - 1024);
            send_sample(sp, ms, 1'b0);
        end
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        program_all(24'h001800, 24'h000800, 24'h002000, 31'd1000, 31'd50000, 17'd1000);
        program_reg(REG_SPARE_A, '1);
        program_reg(REG_SPARE_B, 31'h12345);
        send_sample(16'sh7FFF, 16'sh8000, 1'b0);
        send_sample(16'sh8000, 16'sh7FFF, 1'b0);
        send_sample(16'sd0, 16'sd0, 1'b0);
        send_sample(16'sd1, 16'sd0, 1'b0);
        send_sample(-16'sd1, 16'sd0, 1'b0);
        send_sample(16'sd1000, 16'sd0, 1'b0);
        send_sample(16'sd999, 16'sd0, 1'b0);
        send_sample(16'sd20000, -16'sd20000, 1'b0);
        send_sample(16'sd1234, -16'sd999, 1'b1);
        send_sample(-16'sd3, 16'sd0, 1'b0);
        settle();

        program_all('1, '1, '1, '1, '1, '1);
        send_sample(16'sh7FFF, 16'sh8000, 1'b0);
        send_sample(16'sh8000, 16'sh7FFF, 1'b0);
        send_sample(16'sd100, -16'sd100, 1'b0);
        settle();

        // zero limits with separation always on
        program_all(24'h001000, 24'h001000, 24'h000000, '0, '0, '0);
        send_sample(16'sd5, 16'sd0, 1'b0);
        send_sample(16'sd0, 16'sd0, 1'b0);
        send_sample(-16'sd7, 16'sd0, 1'b0);
        settle();

        // build up the integral, then lower its limit
        program_all(24'h000000, 24'h001000, 24'h000000, 31'd100000, '1, '1);
        repeat (3) send_sample(16'sd1000, 16'sd0, 1'b0);
        settle();
        program_reg(REG_INT_LIMIT, 31'd2000);
        send_sample(16'sd0, 16'sd0, 1'b0);
        send_sample(-16'sd1000, 16'sd0, 1'b0);
        settle();

        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            idle_on = (ph % 4 != 1);
            program_reg(REG_KP, pick_value(GAIN_W));
            program_reg(REG_KI, pick_value(GAIN_W));
            program_reg(REG_KD, pick_value(GAIN_W));
            program_reg(REG_INT_LIMIT, pick_value(LIMIT_W));
            program_reg(REG_OUT_LIMIT, pick_value(LIMIT_W));
            program_reg(REG_SEP_THR, LIMIT_W'(pick_threshold()));
            if ($urandom_range(0, 1))
                program_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B,
                            LIMIT_W'($urandom));
            repeat (ITEMS_PER_PHASE) random_sample();
            settle();
        end

        repeat (20) @(posedge clk);
        if (pid.errors == 0 && pid.pending() == 0)
            $display("PASS position_pid_integral_separation");
        else
            $display("FAIL position_pid_integral_separation");
        $finish;
    end

endmodule

// ----- files.f -----
design/ppis_pkg.sv
design/ppis_cfg.sv
design/ppis_core.sv
design/position_pid_integral_separation.sv
design/ppis_checker.sv
verif/tb_top.sv
